### hdl/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg: shared types and constants of the platoon spacing controller
// Field widths, register indexes, sequencer codes and the saturation helper.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int DATA_W     = 32;  // internal signed word
    localparam int WIDE_W     = 34;  // room for a three-term sum before saturation
    localparam int THR_W      = 17;  // throttle command field
    localparam int BRK_W      = 20;  // brake command field
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int L_W        = 31;  // standstill spacing
    localparam int Q8_W       = 25;  // Q8.x registers, one spare bit for a reset of 1.0
    localparam int TG_W       = 20;  // throttle gain, holds its reset at fraction widths up to 24
    localparam int BG_W       = 25;  // brake gain, signed

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 34'sd2147483647;
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -34'sd2147483648;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STANDSTILL  = 3'd0,
        CFG_TIME_GAP    = 3'd1,
        CFG_INV_GAP     = 3'd2,
        CFG_ERR_WEIGHT  = 3'd3,
        CFG_THR_GAIN    = 3'd4,
        CFG_BRK_GAIN    = 3'd5,
        CFG_THR_ADJUST  = 3'd6,
        CFG_BRK_ADJUST  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_POST,
        ST_DONE
    } t_state;

    // one multiply per operation, in dependency order
    typedef enum logic [3:0] {
        OP_V,       // speed scaling
        OP_E1,      // front spacing error
        OP_E2,      // second spacing error
        OP_S1,      // weighted front error plus closing rate
        OP_A1,      // front candidate acceleration
        OP_S2,
        OP_A2,
        OP_C1,      // front throttle or brake
        OP_C2,      // second throttle or brake
        OP_ADJ_B,   // brake adjust
        OP_ADJ_T    // throttle adjust, last operation
    } t_op;

    typedef struct packed {
        logic start;     // input transfer, capture the sample
        logic post_en;   // multiplier result valid, update the destination
        logic load_out;  // move the result to the output register
        t_op  op;
    } t_step;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        if (x > WIDE_MAX) begin
            return WORD_MAX;
        end
        if (x < WIDE_MIN) begin
            return WORD_MIN;
        end
        return x[DATA_W-1:0];
    endfunction

endpackage

### hdl/psb_mulq.sv
// ----------------------------------------------------------------------------
// psb_mulq: shared fixed-point multiplier
// Two-stage: full product, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module psb_mulq
    import psb_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic signed [DATA_W-1:0] o_q
);

    localparam logic [2*DATA_W-1:0] HALF = (2*DATA_W)'(1) << (FRAC_BITS - 1);
    localparam logic [2*DATA_W-1:0] POS_LIM = (2*DATA_W)'(32'h7FFF_FFFF);
    localparam logic [2*DATA_W-1:0] NEG_LIM = (2*DATA_W)'(32'h8000_0000);

    logic signed [2*DATA_W-1:0] r_p;
    logic signed [DATA_W-1:0]   r_q;
    logic signed [DATA_W-1:0]   n_q;
    logic        [2*DATA_W-1:0] mag;
    logic        [2*DATA_W-1:0] rnd;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
        r_q <= n_q;
    end

    // round the magnitude, restore the sign, clip to the word
    always_comb begin
        mag = r_p[2*DATA_W-1] ? (2*DATA_W)'(-r_p) : r_p;
        rnd = (mag + HALF) >> FRAC_BITS;
        if (r_p[2*DATA_W-1]) begin
            n_q = (rnd > NEG_LIM) ? WORD_MIN : -$signed(rnd[DATA_W-1:0]);
        end else begin
            n_q = (rnd > POS_LIM) ? WORD_MAX : $signed(rnd[DATA_W-1:0]);
        end
    end

    assign o_q = r_q;

endmodule

### hdl/psb_ctrl.sv
// ----------------------------------------------------------------------------
// psb_ctrl: operation sequencer
// Steps the shared multiplier through the eleven operations of one sample.
// ----------------------------------------------------------------------------
module psb_ctrl
    import psb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output logic  o_in_ready,
    output t_step o_step
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_V;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        o_in_ready      = 1'b0;
        o_step.start    = 1'b0;
        o_step.post_en  = 1'b0;
        o_step.load_out = 1'b0;
        o_step.op       = r_op;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_step.start = 1'b1;
                    n_op         = OP_V;
                    n_state      = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_RND;
            end
            ST_RND: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                o_step.post_en = 1'b1;
                if (r_op == OP_ADJ_T) begin
                    n_state = ST_DONE;
                end else begin
                    n_op    = t_op'(r_op + 4'd1);
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (i_out_free) begin
                    o_step.load_out = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/platoon_spacing_throttle_brake_unit.sv
// ----------------------------------------------------------------------------
// platoon_spacing_throttle_brake_unit: platoon spacing controller
// Each sample (own speed, offsets to the car ahead and the car two ahead)
// yields one throttle/brake command. From input transfer to a valid result
// a sample passes through eleven multiplications in the one shared
// multiplier, each as product, round and saturate, and accumulate, and
// then the load of the output register; the input is ready again on the
// following cycle, so a new sample is taken only once the last is done.
// The output register decouples the two sides: a finished result may wait
// for the consumer while the next sample is taken, and the sequencer only
// stalls at the end of that next sample if the result is still unclaimed.
// Configuration writes are taken at any edge with i_cfg_we high and should
// only be made while the block is idle. The first sample after reset gives
// zero closing rates. All intermediate sums and products saturate to
// signed 32 bits; inactive command fields read zero.
// ----------------------------------------------------------------------------
module platoon_spacing_throttle_brake_unit
    import psb_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // sample input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [31:0]    i_own_speed,
    input  logic signed [31:0]    i_gap_front,
    input  logic signed [31:0]    i_gap_second,
    // command output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [THR_W-1:0]      o_throttle_cmd,
    output logic [BRK_W-1:0]      o_brake_cmd
);

    // Constants that scale with the fraction width
    localparam longint ONE          = longint'(1) << FRAC_BITS;
    localparam longint K_SPEED_L    = ((longint'(28) << FRAC_BITS) + 50) / 100;
    localparam longint RST_THR_L    = ((longint'(36) << FRAC_BITS) + 500) / 1000;
    localparam longint RST_BRK_L    = -(((longint'(54) << FRAC_BITS) + 50) / 100);

    localparam logic signed [DATA_W-1:0] K_SPEED  = DATA_W'(K_SPEED_L);
    localparam logic signed [DATA_W-1:0] THR_CAP  = DATA_W'(ONE);
    localparam logic signed [DATA_W-1:0] BRK_CAP  = DATA_W'(15 * ONE);
    localparam logic [L_W-1:0]           RST_L    = L_W'(5 * ONE);
    localparam logic [Q8_W-1:0]          RST_Q8   = Q8_W'(ONE);
    localparam logic [TG_W-1:0]          RST_TG   = TG_W'(RST_THR_L);
    localparam logic signed [BG_W-1:0]   RST_BG   = BG_W'(RST_BRK_L);

    // Configuration registers
    logic [L_W-1:0]         r_standstill;
    logic [Q8_W-1:0]        r_time_gap;
    logic [Q8_W-1:0]        r_inv_gap;
    logic [Q8_W-1:0]        r_err_weight;
    logic [TG_W-1:0]        r_thr_gain;
    logic signed [BG_W-1:0] r_brk_gain;
    logic [Q8_W-1:0]        r_thr_adjust;
    logic [Q8_W-1:0]        r_brk_adjust;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_standstill <= RST_L;
            r_time_gap   <= RST_Q8;
            r_inv_gap    <= RST_Q8;
            r_err_weight <= RST_Q8;
            r_thr_gain   <= RST_TG;
            r_brk_gain   <= RST_BG;
            r_thr_adjust <= RST_Q8;
            r_brk_adjust <= RST_Q8;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STANDSTILL: r_standstill <= i_cfg_wdata;
                CFG_TIME_GAP:   r_time_gap   <= Q8_W'(i_cfg_wdata[23:0]);
                CFG_INV_GAP:    r_inv_gap    <= Q8_W'(i_cfg_wdata[23:0]);
                CFG_ERR_WEIGHT: r_err_weight <= Q8_W'(i_cfg_wdata[23:0]);
                CFG_THR_GAIN:   r_thr_gain   <= TG_W'(i_cfg_wdata[15:0]);
                CFG_BRK_GAIN:   r_brk_gain   <= BG_W'($signed(i_cfg_wdata[18:0]));
                CFG_THR_ADJUST: r_thr_adjust <= Q8_W'(i_cfg_wdata[23:0]);
                CFG_BRK_ADJUST: r_brk_adjust <= Q8_W'(i_cfg_wdata[23:0]);
                default: ;
            endcase
        end
    end

    // Sequencer
    t_step step;
    logic  out_free;
    logic  r_out_valid;

    assign out_free = !r_out_valid || i_out_ready;

    psb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_in_ready (o_in_ready),
        .o_step     (step)
    );

    // Working registers of one sample
    logic signed [DATA_W-1:0] r_speed, r_d1, r_d2;
    logic signed [DATA_W-1:0] r_v, r_r1, r_r2, r_e1, r_e2, r_lead, r_s;
    logic signed [DATA_W-1:0] r_a1, r_a2, r_t1, r_b1;
    logic                     r_t2_pos, r_b2_pos;
    // Sample history
    logic signed [DATA_W-1:0] r_prev1, r_prev2;
    logic                     r_primed;

    // Shared multiplier and its operand selection
    logic signed [DATA_W-1:0] mul_a, mul_b, mul_q;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step.op) inside
            OP_V: begin
                mul_a = r_speed;
                mul_b = K_SPEED;
            end
            OP_E1: begin
                mul_a = $signed(DATA_W'(r_time_gap));
                mul_b = r_v;
            end
            OP_E2: begin
                mul_a = $signed(DATA_W'(r_time_gap));
                mul_b = r_lead;
            end
            OP_S1: begin
                mul_a = $signed(DATA_W'(r_err_weight));
                mul_b = r_e1;
            end
            OP_S2: begin
                mul_a = $signed(DATA_W'(r_err_weight));
                mul_b = r_e2;
            end
            OP_A1, OP_A2: begin
                mul_a = $signed(DATA_W'(r_inv_gap));
                mul_b = r_s;
            end
            OP_C1: begin
                mul_a = r_a1;
                mul_b = (r_a1 > 0) ? $signed(DATA_W'(r_thr_gain)) : DATA_W'(r_brk_gain);
            end
            OP_C2: begin
                mul_a = r_a2;
                mul_b = (r_a2 > 0) ? $signed(DATA_W'(r_thr_gain)) : DATA_W'(r_brk_gain);
            end
            OP_ADJ_B: begin
                mul_a = r_b1;
                mul_b = $signed(DATA_W'(r_brk_adjust));
            end
            OP_ADJ_T: begin
                mul_a = r_t1;
                mul_b = $signed(DATA_W'(r_thr_adjust));
            end
            default: ;
        endcase
    end

    psb_mulq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mulq (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_q   (mul_q)
    );

    // Accumulate stage: add, saturate and clip each product into its
    // destination. Sums are formed at full width and saturated once.
    always_ff @(posedge i_clk) begin
        if (step.start) begin
            // offsets become distances: negate, saturating the most negative
            r_speed <= i_own_speed;
            r_d1    <= sat32(-WIDE_W'(i_gap_front));
            r_d2    <= sat32(-WIDE_W'(i_gap_second));
        end
        if (step.post_en) begin
            case (step.op)
                OP_V: begin
                    r_v <= mul_q;
                    // no history yet: closing rates are zero
                    r_r1 <= r_primed ? sat32(WIDE_W'(r_d1) - WIDE_W'(r_prev1)) : '0;
                    r_r2 <= r_primed ? sat32(WIDE_W'(r_d2) - WIDE_W'(r_prev2)) : '0;
                end
                OP_E1: begin
                    r_e1   <= sat32(WIDE_W'(r_d1) + $signed(WIDE_W'(r_standstill))
                                    + WIDE_W'(mul_q));
                    r_lead <= sat32(WIDE_W'(r_v) - WIDE_W'(r_r1));
                end
                OP_E2: begin
                    r_e2 <= sat32(WIDE_W'(r_d2) + $signed(WIDE_W'(r_standstill))
                                  + WIDE_W'(mul_q));
                end
                OP_S1: r_s  <= sat32(WIDE_W'(r_r1) + WIDE_W'(mul_q));
                OP_A1: r_a1 <= sat32(-WIDE_W'(mul_q));
                OP_S2: r_s  <= sat32(WIDE_W'(r_r2) + WIDE_W'(mul_q));
                OP_A2: r_a2 <= sat32(-WIDE_W'(mul_q));
                OP_C1: begin
                    if (r_a1 > 0) begin
                        r_t1 <= (mul_q > THR_CAP) ? THR_CAP : mul_q;
                        r_b1 <= '0;
                    end else begin
                        // a positive brake gain gives a negative product: drop it
                        r_t1 <= '0;
                        r_b1 <= (mul_q < 0) ? '0 : ((mul_q > BRK_CAP) ? BRK_CAP : mul_q);
                    end
                end
                OP_C2: begin
                    r_t2_pos <= (r_a2 > 0) && (mul_q > 0);
                    r_b2_pos <= !(r_a2 > 0) && (mul_q > 0);
                end
                OP_ADJ_B: begin
                    if (r_t2_pos) begin
                        r_b1 <= (mul_q > BRK_CAP) ? BRK_CAP : mul_q;
                    end
                end
                OP_ADJ_T: begin
                    if (r_b2_pos) begin
                        r_t1 <= (mul_q > THR_CAP) ? THR_CAP : mul_q;
                    end
                end
                default: ;
            endcase
        end
    end

    // History: advance once the sample is complete
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev1  <= '0;
            r_prev2  <= '0;
            r_primed <= 1'b0;
        end else if (step.load_out) begin
            r_prev1  <= r_d1;
            r_prev2  <= r_d2;
            r_primed <= 1'b1;
        end
    end

    // Output register
    logic [THR_W-1:0] r_out_thr;
    logic [BRK_W-1:0] r_out_brk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.load_out) begin
            r_out_thr <= r_t1[THR_W-1:0];
            r_out_brk <= r_b1[BRK_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_throttle_cmd = r_out_thr;
    assign o_brake_cmd    = r_out_brk;

endmodule

### hdl/psb_checker.sv
// ----------------------------------------------------------------------------
// psb_checker: port-level checks of the platoon spacing controller
// Bound to the top level; watches transfers and the command fields.
// ----------------------------------------------------------------------------
module psb_checker
    import psb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [THR_W-1:0]      o_throttle_cmd,
    input logic [BRK_W-1:0]      o_brake_cmd
);

    // result stays offered until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_throttle_cmd) && $stable(o_brake_cmd))
        else $error("result changed while stalled");

    // one sample at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready while a sample is in work");

    // throttle and brake are never commanded together
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_throttle_cmd == '0) || (o_brake_cmd == '0))
        else $error("throttle and brake both active");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

endmodule

bind platoon_spacing_throttle_brake_unit psb_checker u_psb_checker (.*);

### tb/platoon_spacing_throttle_brake_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// platoon_spacing_throttle_brake_unit_checker: command scoreboard
// Watches the register, sample and command ports. Keeps its own copy of the
// registers and the distance history, works out the throttle/brake command
// for every sample transfer and compares it with the next command transfer.
// ----------------------------------------------------------------------------
module platoon_spacing_throttle_brake_unit_checker
    import psb_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic signed [31:0]    i_own_speed,
    input  logic signed [31:0]    i_gap_front,
    input  logic signed [31:0]    i_gap_second,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [THR_W-1:0]      i_throttle_cmd,
    input  logic [BRK_W-1:0]      i_brake_cmd,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked
);

    localparam longint ONE      = longint'(1) << FRAC_BITS;
    localparam longint HALF     = ONE >>> 1;
    localparam longint SPEED_K  = ((longint'(28) << FRAC_BITS) + 50) / 100;
    localparam longint THR_CAP  = ONE;
    localparam longint BRK_CAP  = 15 * ONE;
    localparam longint WORD_HI  = 64'sh7FFF_FFFF;
    localparam longint WORD_LO  = -64'sh8000_0000;
    localparam int     REG24_W  = 24;
    localparam int     TGAIN_W  = 16;
    localparam int     BGAIN_W  = 19;
    localparam int     PRINT_CAP = 50;

    typedef struct packed {
        logic [THR_W-1:0] throttle;
        logic [BRK_W-1:0] brake;
    } t_command;

    longint standstill, gap_time, gap_inverse, err_weight;
    longint thr_gain, brk_gain, thr_adjust, brk_adjust;
    longint prev_front, prev_second;
    bit     primed;

    t_command expected_cmds[$];
    t_command oldest;
    int       mismatch_count = 0;
    int       checked_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_checked    = checked_count;

    function automatic longint clamp_word(input longint x);
        if (x > WORD_HI) begin
            return WORD_HI;
        end
        if (x < WORD_LO) begin
            return WORD_LO;
        end
        return x;
    endfunction

    // fixed-point product, rounded half away from zero
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) begin
            return clamp_word((p + HALF) >>> FRAC_BITS);
        end
        return clamp_word(-((-p + HALF) >>> FRAC_BITS));
    endfunction

    function automatic void split_accel(input longint acc, output longint thr,
                                        output longint brk);
        longint b;
        if (acc > 0) begin
            b   = fx_mul(acc, thr_gain);
            thr = (b < THR_CAP) ? b : THR_CAP;
            brk = 0;
        end else begin
            b   = fx_mul(acc, brk_gain);
            thr = 0;
            brk = (b < 0) ? 0 : ((b < BRK_CAP) ? b : BRK_CAP);
        end
    endfunction

    function automatic t_command predict_command(input logic signed [31:0] spd,
                                                 input logic signed [31:0] fr,
                                                 input logic signed [31:0] sc);
        longint d1, d2, v, r1, r2, e1, e2, lead, a1, a2, t1, b1, t2, b2, adj;
        t_command cmd;
        d1 = clamp_word(-longint'(fr));
        d2 = clamp_word(-longint'(sc));
        // first sample: no history, so both closing rates come out zero
        if (!primed) begin
            prev_front  = d1;
            prev_second = d2;
        end
        v    = fx_mul(longint'(spd), SPEED_K);
        r1   = clamp_word(d1 - prev_front);
        r2   = clamp_word(d2 - prev_second);
        e1   = clamp_word(d1 + standstill + fx_mul(gap_time, v));
        lead = clamp_word(v - r1);
        e2   = clamp_word(d2 + standstill + fx_mul(gap_time, lead));
        a1   = clamp_word(-fx_mul(gap_inverse, clamp_word(r1 + fx_mul(err_weight, e1))));
        a2   = clamp_word(-fx_mul(gap_inverse, clamp_word(r2 + fx_mul(err_weight, e2))));
        split_accel(a1, t1, b1);
        split_accel(a2, t2, b2);
        if (t2 > 0) begin
            adj = fx_mul(b1, brk_adjust);
            b1  = (adj < BRK_CAP) ? adj : BRK_CAP;
        end
        if (b2 > 0) begin
            adj = fx_mul(t1, thr_adjust);
            t1  = (adj < THR_CAP) ? adj : THR_CAP;
        end
        prev_front   = d1;
        prev_second  = d2;
        primed       = 1'b1;
        cmd.throttle = t1[THR_W-1:0];
        cmd.brake    = b1[BRK_W-1:0];
        return cmd;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] command check: %s", $time, what);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            standstill  = 5 * ONE;
            gap_time    = ONE;
            gap_inverse = ONE;
            err_weight  = ONE;
            thr_gain    = ((longint'(36) << FRAC_BITS) + 500) / 1000;
            brk_gain    = -(((longint'(54) << FRAC_BITS) + 50) / 100);
            thr_adjust  = ONE;
            brk_adjust  = ONE;
            prev_front  = 0;
            prev_second = 0;
            primed      = 1'b0;
            expected_cmds.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STANDSTILL: standstill  = longint'(i_cfg_wdata[L_W-1:0]);
                    CFG_TIME_GAP:   gap_time    = longint'(i_cfg_wdata[REG24_W-1:0]);
                    CFG_INV_GAP:    gap_inverse = longint'(i_cfg_wdata[REG24_W-1:0]);
                    CFG_ERR_WEIGHT: err_weight  = longint'(i_cfg_wdata[REG24_W-1:0]);
                    CFG_THR_GAIN:   thr_gain    = longint'(i_cfg_wdata[TGAIN_W-1:0]);
                    CFG_BRK_GAIN:   brk_gain    = longint'($signed(i_cfg_wdata[BGAIN_W-1:0]));
                    CFG_THR_ADJUST: thr_adjust  = longint'(i_cfg_wdata[REG24_W-1:0]);
                    CFG_BRK_ADJUST: brk_adjust  = longint'(i_cfg_wdata[REG24_W-1:0]);
                    default: ;
                endcase
            end
            // retire before predicting, so a stray command never pairs with
            // the sample taken on the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch($sformatf("throttle %h brake %h with no sample outstanding",
                                              i_throttle_cmd, i_brake_cmd));
                end else begin
                    oldest = expected_cmds.pop_front();
                    checked_count++;
                    if (i_throttle_cmd !== oldest.throttle) begin
                        report_mismatch($sformatf("result %0d throttle %h, predicted %h",
                                                  checked_count, i_throttle_cmd,
                                                  oldest.throttle));
                    end
                    if (i_brake_cmd !== oldest.brake) begin
                        report_mismatch($sformatf("result %0d brake %h, predicted %h",
                                                  checked_count, i_brake_cmd, oldest.brake));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_cmds.push_back(predict_command(i_own_speed, i_gap_front,
                                                        i_gap_second));
            end
            o_pending <= expected_cmds.size();
        end
    end

endmodule

### tb/platoon_spacing_throttle_brake_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// platoon_spacing_throttle_brake_unit_tb: platoon spacing controller bench
// Drives samples through the valid/ready input under eight register
// settings (reset state, register maxima, all-zeros, positive brake gain, large
// adjust factors, random) and four idling mixes. A side checker predicts
// and compares every command; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module platoon_spacing_throttle_brake_unit_tb;
    import psb_pkg::*;

    localparam int FRAC             = 16;
    localparam int N_PHASES         = 8;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int SETTLE_CYCLES    = 8;    // pause before a register write
    localparam int DRAIN_CYCLES     = 40;   // a little over one sample's latency
    // Even with long random gaps and stalls a healthy run never goes this
    // long without a transfer.
    localparam int STALL_LIMIT      = 4000;

    logic                  i_clk      = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    t_cfg_idx              cfg_idx    = CFG_STANDSTILL;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic signed [31:0]    own_speed  = '0;
    logic signed [31:0]    gap_front  = '0;
    logic signed [31:0]    gap_second = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [THR_W-1:0]      throttle_cmd;
    logic [BRK_W-1:0]      brake_cmd;

    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int samples_sent    = 0;
    int quiet_cycles    = 0;
    int mismatches, pending, checked;

    always #5 i_clk = ~i_clk;

    platoon_spacing_throttle_brake_unit #(
        .FRAC_BITS(FRAC)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_own_speed    (own_speed),
        .i_gap_front    (gap_front),
        .i_gap_second   (gap_second),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_throttle_cmd (throttle_cmd),
        .o_brake_cmd    (brake_cmd)
    );

    platoon_spacing_throttle_brake_unit_checker #(
        .FRAC_BITS(FRAC)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_own_speed    (own_speed),
        .i_gap_front    (gap_front),
        .i_gap_second   (gap_second),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_throttle_cmd (throttle_cmd),
        .i_brake_cmd    (brake_cmd),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // whole units to Q16.16
    function automatic logic signed [31:0] q16(input int whole);
        return 32'(whole * 65536);
    endfunction

    function automatic logic signed [31:0] corner_value(input int k);
        case (k)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Offer one sample: idle first at the current rate, then hold valid and
    // the payload until the transfer. Valid is touched once per edge, so a
    // back-to-back sample simply keeps it high.
    task automatic send_sample(input logic signed [31:0] spd,
                               input logic signed [31:0] fr,
                               input logic signed [31:0] sc);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        own_speed  <= spd;
        gap_front  <= fr;
        gap_second <= sc;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        samples_sent++;
    endtask

    // The pending count is registered, so the first edge here already
    // includes the sample transferred on the edge we were called at.
    task automatic wait_for_idle(input int settle);
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // Hold the write enable high; the caller drops it after the last write.
    task automatic load_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Receiver: stall at the rate of the current phase.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Watchdog: count edges with neither a sample nor a command transfer.
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic signed [31:0] spd, fr, sc;
        logic [CFG_DATA_W-1:0] l_val, h_val, ih_val, w_val, tg_val, bg_val, ta_val, ba_val;
        int roll;
        int traj_speed, traj_front, traj_second;

        traj_speed  = 20 << 16;
        traj_front  = 30 << 16;
        traj_second = 60 << 16;

        // hold reset from the start, then release
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                // Let the last command drain before touching the registers.
                wait_for_idle(SETTLE_CYCLES);

                // plausible spread: gap 0.25..3 s, weight up to 4, gains modest
                l_val  = 31'($urandom_range(0, 20 << 16));
                h_val  = 31'($urandom_range(32'h4000, 32'h30000));
                ih_val = 31'((64'd1 << 32) / h_val);
                w_val  = 31'($urandom_range(32'h2000, 32'h40000));
                tg_val = 31'($urandom_range(0, 32'h4000));
                bg_val = {12'd0, 19'(-int'($urandom_range(0, 32'h20000)))};
                ta_val = 31'($urandom_range(32'h8000, 32'h18000));
                ba_val = 31'($urandom_range(32'h8000, 32'h18000));
                case (ph)
                    1: begin
                        // every register at its top (brake gain most negative)
                        l_val  = 31'h7FFF_FFFF;
                        h_val  = 31'hFF_FFFF;
                        ih_val = 31'hFF_FFFF;
                        w_val  = 31'hFF_FFFF;
                        tg_val = 31'hFFFF;
                        bg_val = {12'd0, 19'h4_0000};
                        ta_val = 31'hFF_FFFF;
                        ba_val = 31'hFF_FFFF;
                    end
                    2: begin
                        l_val  = '0;
                        h_val  = '0;
                        ih_val = '0;
                        w_val  = '0;
                        tg_val = '0;
                        bg_val = '0;
                        ta_val = '0;
                        ba_val = '0;
                    end
                    3: begin
                        // positive brake gain: negative brake products clamp to zero
                        bg_val = {12'd0, 19'($urandom_range(1, 32'h3FFFF))};
                    end
                    4: begin
                        // adjust factors of one and above, so the caps bite again
                        ta_val = 31'($urandom_range(32'h10000, 32'hFF_FFFF));
                        ba_val = 31'($urandom_range(32'h10000, 32'hFF_FFFF));
                    end
                    5: begin
                        // back to the reset values, written explicitly
                        l_val  = 31'(5 << FRAC);
                        h_val  = 31'(1 << FRAC);
                        ih_val = 31'(1 << FRAC);
                        w_val  = 31'(1 << FRAC);
                        tg_val = 31'(((36 << FRAC) + 500) / 1000);
                        bg_val = {12'd0, 19'(-(((54 << FRAC) + 50) / 100))};
                        ta_val = 31'(1 << FRAC);
                        ba_val = 31'(1 << FRAC);
                    end
                    6: begin
                        // anything the register widths allow
                        l_val  = 31'($urandom);
                        h_val  = 31'($urandom_range(0, 32'hFF_FFFF));
                        ih_val = 31'($urandom_range(0, 32'hFF_FFFF));
                        w_val  = 31'($urandom_range(0, 32'hFF_FFFF));
                        tg_val = 31'($urandom_range(0, 32'hFFFF));
                        bg_val = 31'($urandom_range(0, 32'h7_FFFF));
                        ta_val = 31'($urandom_range(0, 32'hFF_FFFF));
                        ba_val = 31'($urandom_range(0, 32'hFF_FFFF));
                    end
                    default: ;
                endcase
                load_reg(CFG_STANDSTILL, l_val);
                load_reg(CFG_TIME_GAP, h_val);
                load_reg(CFG_INV_GAP, ih_val);
                load_reg(CFG_ERR_WEIGHT, w_val);
                load_reg(CFG_THR_GAIN, tg_val);
                load_reg(CFG_BRK_GAIN, bg_val);
                load_reg(CFG_THR_ADJUST, ta_val);
                load_reg(CFG_BRK_ADJUST, ba_val);
                cfg_we <= 1'b0;
            end

            // rotate the idling mix: free running, sparse sender, slow
            // receiver, light idling on both sides
            case (ph % 4)
                0: begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 0;
                end
                1: begin
                    send_idle_pct   = 86;
                    ready_stall_pct = 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 86;
                end
                default: begin
                    send_idle_pct   = 17;
                    ready_stall_pct = 17;
                end
            endcase

            if (ph == 0) begin
                // First sample after reset: no history, closing rates zero.
                // Own car close (brake) while the second car is far (throttle).
                send_sample(q16(0), q16(2), q16(20));
                // own car far (throttle) while the second car is close (brake)
                send_sample(q16(0), q16(20), q16(2));
                send_sample(q16(10), q16(10), q16(20));
                send_sample(q16(0), q16(0), q16(0));
                // most negative offsets: negation saturates
                send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
                send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
                send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
                send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
                send_sample(-32'sd1, -32'sd1, -32'sd1);
                send_sample(32'sd1, 32'sd1, 32'sd1);
                // full-scale jumps give saturating closing rates
                send_sample(q16(1), 32'sh8000_0000, q16(0));
                send_sample(q16(0), 32'sh7FFF_FFFF, 32'sh8000_0000);
                send_sample(32'sh7FFF_0000, q16(100), q16(200));
                // a short closing-in manoeuvre at steady speed
                send_sample(q16(30), q16(40), q16(80));
                send_sample(q16(30), q16(38), q16(81));
                send_sample(q16(30), q16(36), q16(82));
                send_sample(q16(30), q16(35), q16(70));
                // negative offsets: car ahead reported behind
                send_sample(q16(0), q16(-5), q16(-10));
                send_sample(q16(5), q16(5), q16(10));
                send_sample(q16(-20), q16(3), q16(4));
            end

            repeat (RANDOM_PER_PHASE) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    // Follow a plausible drive: small steps keep the closing
                    // rates meaningful; now and then start a fresh drive.
                    if (roll < 3) begin
                        traj_speed  = $urandom_range(0, 150 << 16);
                        traj_front  = $urandom_range(0, 120 << 16);
                        traj_second = $urandom_range(0, 240 << 16);
                    end
                    traj_speed  += int'($urandom_range(0, 2 << 16)) - (1 << 16);
                    traj_front  += int'($urandom_range(0, 1 << 16)) - (1 << 15);
                    traj_second += int'($urandom_range(0, 1 << 16)) - (1 << 15);
                    if (traj_speed < 0)          traj_speed  = 0;
                    if (traj_speed > 160 << 16)  traj_speed  = 160 << 16;
                    if (traj_front < 0)          traj_front  = 0;
                    if (traj_front > 120 << 16)  traj_front  = 120 << 16;
                    if (traj_second < 0)         traj_second = 0;
                    if (traj_second > 240 << 16) traj_second = 240 << 16;
                    spd = traj_speed;
                    fr  = traj_front;
                    sc  = traj_second;
                end else if (roll < 90) begin
                    // noise across the whole word
                    spd = $urandom;
                    fr  = $urandom;
                    sc  = $urandom;
                end else begin
                    spd = corner_value($urandom_range(4));
                    fr  = corner_value($urandom_range(4));
                    sc  = corner_value($urandom_range(4));
                end
                send_sample(spd, fr, sc);
            end
            in_valid <= 1'b0;
        end

        // drain, then give the block one more sample time to misbehave
        wait_for_idle(DRAIN_CYCLES);

        $display("%0d samples sent, %0d commands compared, %0d register settings",
                 samples_sent, checked, N_PHASES);
        $display("idling mixes: free running, sender gaps, receiver stalls, both sides");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/psb_pkg.sv
hdl/psb_mulq.sv
hdl/psb_ctrl.sv
hdl/platoon_spacing_throttle_brake_unit.sv
hdl/psb_checker.sv
tb/platoon_spacing_throttle_brake_unit_checker.sv
tb/platoon_spacing_throttle_brake_unit_tb.sv
